[sv/wgm_pkg.sv]
// ----------------------------------------------------------------------------
// wgm_pkg: shared definitions for the wildcard glob matcher
// Pattern store sizes, command codes, wildcard bytes and ASCII case folding.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // pattern store depth and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int POS_N       = MAX_PATTERN + 1;          // active positions
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);  // holds 0..MAX_PATTERN
    localparam int IDX_W       = $clog2(MAX_PATTERN);      // store address
    localparam int SCAN_LVL    = $clog2(POS_N);            // prefix-scan levels

    // wildcard bytes
    localparam logic [7:0] GLOB_ANY_RUN = 8'h2A;  // '*'
    localparam logic [7:0] GLOB_ANY_ONE = 8'h3F;  // '?'

    // ASCII letter range for folding
    localparam logic [7:0] ASCII_UP_A   = 8'h41;
    localparam logic [7:0] ASCII_UP_Z   = 8'h5A;
    localparam logic [7:0] ASCII_CASE   = 8'h20;

    // command codes carried in func
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_NAME   = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    // fold upper-case ASCII to lower case when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ci);
        logic [7:0] r;
        r = c;
        if (ci && (c >= ASCII_UP_A) && (c <= ASCII_UP_Z)) begin
            r = c + ASCII_CASE;
        end
        return r;
    endfunction

endpackage

[sv/wildcard_glob_matcher.sv]
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: streamed name against stored glob pattern
// Holds up to MAX_PATTERN pattern bytes ('*' any run, '?' any byte) and a
// vector of active pattern positions that advances one name byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage: load the pattern with append transactions (func 0), empty it with a
// clear (func 1), then send the name one byte per name transaction (func 2)
// and finish with an end-of-name transaction (func 3), which returns one
// result: matched, plus pattern_overflow if bytes were dropped since the last
// clear. Any pattern change abandons a name in progress. The block takes one
// transaction every cycle unless input stalls; an end-of-name result is
// registered into the output slot, or the skid slot when that is held. The
// cycle is set by the single-pass update of the active-position vector: 32
// parallel byte compares followed by a six-level prefix scan that closes over
// runs of '*'. A two-deep output buffer lets input keep flowing while one
// result waits; input stalls only when both output slots are full. No clearing
// pass after reset: the store is only read below the current pattern length.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic       o_pattern_overflow
);

    localparam logic [wgm_pkg::POS_N-1:0] START_POS = {{(wgm_pkg::POS_N-1){1'b0}}, 1'b1};

    // state
    logic [7:0]                    r_pat [wgm_pkg::MAX_PATTERN];
    logic [wgm_pkg::LEN_W-1:0]     r_len;
    logic                          r_ovf;
    logic                          r_ci;
    logic [wgm_pkg::POS_N-1:0]     r_active;   // closed active positions
    logic [wgm_pkg::POS_N-1:0]     r_lead;     // start position closed over '*'

    // output buffer
    logic r_out_valid, r_out_matched, r_out_ovf;
    logic r_sk_valid,  r_sk_matched,  r_sk_ovf;

    logic                          in_accept;
    logic                          out_pop;
    logic                          push;
    logic                          room;
    logic                          store_full;
    logic                          res_matched;
    wgm_pkg::t_func                func;
    logic [7:0]                    name_fc;
    logic [wgm_pkg::POS_N-1:0]     n_lead;
    logic [wgm_pkg::POS_N-1:0]     n_step;     // after one name byte, before closure
    logic [wgm_pkg::POS_N-1:0]     n_active;   // after closure
    logic [wgm_pkg::POS_N-1:0]     prop;       // '*' at position j-1 carries into j
    logic [wgm_pkg::POS_N-1:0]     scan_g [wgm_pkg::SCAN_LVL+1];
    logic [wgm_pkg::POS_N-1:0]     scan_p [wgm_pkg::SCAN_LVL+1];

    // handshakes
    assign func        = wgm_pkg::t_func'(i_func);
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_sk_valid;
    assign in_accept   = i_in_valid && !r_sk_valid;
    assign out_pop     = r_out_valid && !i_out_stall;
    assign push        = in_accept && (func == wgm_pkg::FUNC_END);
    assign room        = out_pop || !r_out_valid;
    assign store_full  = (r_len == wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN));

    // end-of-name result from the current state
    assign res_matched = (r_len == '0) || r_active[r_len];

    // leading-star closure after an append
    always_comb begin
        n_lead = r_lead;
        if (!store_full) begin
            n_lead[r_len + 1'b1] = r_lead[r_len] && (i_data_byte == wgm_pkg::GLOB_ANY_RUN);
        end
    end

    // one name byte: every live position steps in parallel
    assign name_fc = wgm_pkg::fold_byte(i_data_byte, r_ci);

    always_comb begin
        n_step  = '0;
        prop    = '0;
        for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
            if (wgm_pkg::LEN_W'(i) < r_len) begin
                prop[i+1] = (r_pat[i] == wgm_pkg::GLOB_ANY_RUN);
                if (r_active[i]) begin
                    if (r_pat[i] == wgm_pkg::GLOB_ANY_RUN) begin
                        n_step[i] = 1'b1;
                    end else if ((r_pat[i] == wgm_pkg::GLOB_ANY_ONE) ||
                                 (wgm_pkg::fold_byte(r_pat[i], r_ci) == name_fc)) begin
                        n_step[i+1] = 1'b1;
                    end
                end
            end
        end
    end

    // star closure as a parallel prefix scan (generate / propagate)
    always_comb begin
        scan_g[0] = n_step;
        scan_p[0] = prop;
        for (int l = 0; l < wgm_pkg::SCAN_LVL; l++) begin
            scan_g[l+1] = scan_g[l];
            scan_p[l+1] = scan_p[l];
            for (int j = 0; j < wgm_pkg::POS_N; j++) begin
                if (j >= (1 << l)) begin
                    scan_g[l+1][j] = scan_g[l][j] | (scan_p[l][j] & scan_g[l][j - (1 << l)]);
                    scan_p[l+1][j] = scan_p[l][j] & scan_p[l][j - (1 << l)];
                end
            end
        end
        n_active = scan_g[wgm_pkg::SCAN_LVL];
    end

    // pattern store write
    always_ff @(posedge i_clk) begin
        if (in_accept && (func == wgm_pkg::FUNC_APPEND) && !store_full) begin
            r_pat[r_len[wgm_pkg::IDX_W-1:0]] <= i_data_byte;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_ci        <= 1'b0;
            r_active    <= START_POS;
            r_lead      <= START_POS;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ci <= i_cfg_data;
            end
            if (in_accept) begin
                unique case (func)
                    wgm_pkg::FUNC_APPEND: begin
                        if (store_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_len  <= r_len + 1'b1;
                            r_lead <= n_lead;
                        end
                        r_active <= n_lead;
                    end
                    wgm_pkg::FUNC_CLEAR: begin
                        r_len    <= '0;
                        r_ovf    <= 1'b0;
                        r_lead   <= START_POS;
                        r_active <= START_POS;
                    end
                    wgm_pkg::FUNC_NAME: begin
                        r_active <= n_active;
                    end
                    wgm_pkg::FUNC_END: begin
                        r_active <= r_lead;
                    end
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
            // output buffer occupancy
            if (room) begin
                r_out_valid <= r_sk_valid || push;
                r_sk_valid  <= r_sk_valid && push;
            end else if (push) begin
                r_sk_valid  <= 1'b1;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (room) begin
            if (r_sk_valid) begin
                r_out_matched <= r_sk_matched;
                r_out_ovf     <= r_sk_ovf;
                r_sk_matched  <= res_matched;
                r_sk_ovf      <= r_ovf;
            end else begin
                r_out_matched <= res_matched;
                r_out_ovf     <= r_ovf;
            end
        end else if (push) begin
            r_sk_matched <= res_matched;
            r_sk_ovf     <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_matched          = r_out_matched;
    assign o_pattern_overflow = r_out_ovf;

    // assertions
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid slot holds a result while the output slot is empty");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN))
        else $error("pattern length beyond store depth");

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >> (r_len + 1'b1)) == '0)
        else $error("active position beyond pattern end");

    a_clear_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (func == wgm_pkg::FUNC_CLEAR)) |=>
            ((r_len == '0) && !r_ovf && (r_active == START_POS)))
        else $error("clear did not empty the pattern");

endmodule

[tb/glob_match_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_match_checker: scoreboard for the wildcard glob matcher
// Watches the configuration, input and result channels, keeps its own copy of
// the pattern and the active-position vector, predicts the verdict of every
// end-of-name transaction and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module glob_match_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_matched,
    input  logic       i_pattern_overflow,
    output int         o_mismatches,
    output int         o_verdicts_due
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // predicted matcher state
    logic [7:0]               glob_bytes [wgm_pkg::MAX_PATTERN];
    int                       glob_len;
    logic [wgm_pkg::POS_N-1:0] live_pos;
    logic                     ovf_seen;
    logic                     nocase;

    t_verdict verdicts_due [$];
    int       mismatches = 0;

    // ASCII lower-casing, only when the case-insensitive mode is on
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (nocase && c >= wgm_pkg::ASCII_UP_A && c <= wgm_pkg::ASCII_UP_Z) begin
            return c + wgm_pkg::ASCII_CASE;
        end
        return c;
    endfunction

    // a live '*' also makes the position after it live (ripples forward)
    task automatic close_runs();
        for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
            if (i < glob_len && live_pos[i] && glob_bytes[i] == wgm_pkg::GLOB_ANY_RUN) begin
                live_pos[i+1] = 1'b1;
            end
        end
    endtask

    task automatic restart_scan();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        close_runs();
    endtask

    // one name byte: '*' stays, '?' and equal literals step forward
    task automatic advance_scan(input logic [7:0] c);
        logic [wgm_pkg::POS_N-1:0] nxt;
        logic [7:0]                fc;
        nxt = '0;
        fc  = to_lower(c);
        for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
            if (i < glob_len && live_pos[i]) begin
                if (glob_bytes[i] == wgm_pkg::GLOB_ANY_RUN) begin
                    nxt[i] = 1'b1;
                end else if (glob_bytes[i] == wgm_pkg::GLOB_ANY_ONE ||
                             to_lower(glob_bytes[i]) == fc) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        live_pos = nxt;
        close_runs();
    endtask

    task automatic apply_command(input wgm_pkg::t_func f, input logic [7:0] b);
        t_verdict want;
        case (f)
            wgm_pkg::FUNC_APPEND: begin
                if (glob_len < wgm_pkg::MAX_PATTERN) begin
                    glob_bytes[glob_len] = b;
                    glob_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
                restart_scan();
            end
            wgm_pkg::FUNC_CLEAR: begin
                glob_len = 0;
                ovf_seen = 1'b0;
                restart_scan();
            end
            wgm_pkg::FUNC_NAME: begin
                advance_scan(b);
            end
            default: begin
                want.matched  = (glob_len == 0) || live_pos[glob_len];
                want.overflow = ovf_seen;
                verdicts_due.push_back(want);
                restart_scan();
            end
        endcase
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            glob_len = 0;
            ovf_seen = 1'b0;
            nocase   = 1'b0;
            restart_scan();
            verdicts_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                nocase = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(wgm_pkg::t_func'(i_func), i_data_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("result transaction with no verdict pending");
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_matched !== want.matched) begin
                        $error("matched: expected %0b, actual %0b", want.matched, i_matched);
                        mismatches++;
                    end
                    if (i_pattern_overflow !== want.overflow) begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               want.overflow, i_pattern_overflow);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches   <= mismatches;
        o_verdicts_due <= verdicts_due.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the wildcard glob matcher
// Drives pattern loads, clears, name bytes and end-of-name transactions with
// random idle and stall phases, a long result hold-off, and case mode changes
// between phases; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HOLD_CYCLES = 300;   // long result hold-off
    localparam int SETTLE      = 4;     // cycles after the last result
    localparam int TAIL        = 10;
    localparam int STALL_LIMIT = 4000;  // cycles with no transaction at all
    localparam int PHASE_ITEMS = 95;

    logic       i_clk;
    logic       i_rst_n            = 1'b0;
    logic       i_cfg_valid        = 1'b0;
    logic       i_cfg_data         = 1'b0;
    logic       i_in_valid         = 1'b0;
    logic [1:0] i_func             = wgm_pkg::FUNC_CLEAR;
    logic [7:0] i_data_byte        = 8'h00;
    logic       i_out_stall        = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_matched;
    logic       o_pattern_overflow;

    int         mismatch_count;
    int         results_pending;
    int         idle_pct  = 0;
    int         stall_pct = 0;
    int         hold_req  = 0;      // bumped by the sender to request a hold-off
    int         hold_done = 0;      // hold-off requests already served
    int         items_sent = 0;
    logic [7:0] pat_mirror [$];

    wildcard_glob_matcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_matched          (o_matched),
        .o_pattern_overflow (o_pattern_overflow)
    );

    glob_match_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_data_byte        (i_data_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_matched          (o_matched),
        .i_pattern_overflow (o_pattern_overflow),
        .o_mismatches       (mismatch_count),
        .o_verdicts_due     (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                hold_done   = hold_req;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic put_item(input wgm_pkg::t_func f, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        // pattern copy, only used to shape matching names
        if (f == wgm_pkg::FUNC_APPEND && pat_mirror.size() < wgm_pkg::MAX_PATTERN) begin
            pat_mirror.push_back(b);
        end else if (f == wgm_pkg::FUNC_CLEAR) begin
            pat_mirror.delete();
        end
    endtask

    // stop sending and wait for every predicted result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_nocase(input logic v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // byte mix: wildcards, the letters a, b, A, B and z, anything else
    function automatic logic [7:0] random_glyph();
        int r;
        r = $urandom_range(99);
        if (r < 20) return wgm_pkg::GLOB_ANY_RUN;
        if (r < 32) return wgm_pkg::GLOB_ANY_ONE;
        if (r < 75) begin
            case ($urandom_range(4))
                0: return "a";
                1: return "b";
                2: return "A";
                3: return "B";
                default: return "z";
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // a new pattern now and then, then names derived from it, or noise
    task automatic random_burst();
        logic [7:0] nm [$];
        logic [7:0] pb;
        int         r;
        int         len;
        r = $urandom_range(99);
        if (r < 15) begin
            repeat ($urandom_range(1, 6))
                put_item(wgm_pkg::t_func'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (r < 45) begin
            if ($urandom_range(99) < 80) put_item(wgm_pkg::FUNC_CLEAR, 8'($urandom_range(255)));
            len = ($urandom_range(99) < 6) ? $urandom_range(28, 36) : $urandom_range(0, 6);
            repeat (len) put_item(wgm_pkg::FUNC_APPEND, random_glyph());
        end
        repeat ($urandom_range(1, 3)) begin
            nm.delete();
            for (int k = 0; k < pat_mirror.size(); k++) begin
                pb = pat_mirror[k];
                r  = $urandom_range(99);
                if (pb == wgm_pkg::GLOB_ANY_RUN) begin
                    repeat ($urandom_range(3)) nm.push_back(random_glyph());
                end else if (pb == wgm_pkg::GLOB_ANY_ONE || r < 8) begin
                    nm.push_back(random_glyph());
                end else if (r < 30 && (pb | wgm_pkg::ASCII_CASE) >= "a" &&
                             (pb | wgm_pkg::ASCII_CASE) <= "z") begin
                    nm.push_back(pb ^ wgm_pkg::ASCII_CASE);
                end else begin
                    nm.push_back(pb);
                end
            end
            if ($urandom_range(99) < 10) nm.push_back(random_glyph());
            for (int k = 0; k < nm.size(); k++) begin
                // rare pattern change abandons the name in flight
                if (k > 0 && $urandom_range(99) < 3) put_item(wgm_pkg::FUNC_APPEND, random_glyph());
                put_item(wgm_pkg::FUNC_NAME, nm[k]);
            end
            put_item(wgm_pkg::FUNC_END, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int phase_goal;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_nocase(1'b0);

        // directed: empty pattern and empty name
        put_item(wgm_pkg::FUNC_END, 8'h00);
        // byte zero and 0xFF against the empty pattern
        put_item(wgm_pkg::FUNC_NAME, 8'h00);
        put_item(wgm_pkg::FUNC_NAME, 8'hFF);
        put_item(wgm_pkg::FUNC_END, 8'hFF);
        // star-only pattern with an empty name
        put_item(wgm_pkg::FUNC_APPEND, wgm_pkg::GLOB_ANY_RUN);
        put_item(wgm_pkg::FUNC_END, 8'h55);
        // literal '*' in the name, case-sensitive miss
        put_item(wgm_pkg::FUNC_APPEND, "A");
        put_item(wgm_pkg::FUNC_NAME, "x");
        put_item(wgm_pkg::FUNC_NAME, wgm_pkg::GLOB_ANY_RUN);
        put_item(wgm_pkg::FUNC_NAME, "a");
        put_item(wgm_pkg::FUNC_END, 8'h00);
        // '?' against a literal '?' in the name
        put_item(wgm_pkg::FUNC_APPEND, wgm_pkg::GLOB_ANY_ONE);
        put_item(wgm_pkg::FUNC_NAME, "A");
        put_item(wgm_pkg::FUNC_NAME, wgm_pkg::GLOB_ANY_ONE);
        put_item(wgm_pkg::FUNC_END, 8'hAA);
        // clear, then extreme pattern bytes
        put_item(wgm_pkg::FUNC_CLEAR, 8'hFF);
        put_item(wgm_pkg::FUNC_APPEND, 8'h00);
        put_item(wgm_pkg::FUNC_APPEND, 8'hFF);
        put_item(wgm_pkg::FUNC_NAME, 8'h00);
        put_item(wgm_pkg::FUNC_NAME, 8'hFF);
        put_item(wgm_pkg::FUNC_END, 8'h01);
        // pattern change in the middle of a name
        put_item(wgm_pkg::FUNC_NAME, 8'h00);
        put_item(wgm_pkg::FUNC_APPEND, wgm_pkg::GLOB_ANY_RUN);
        put_item(wgm_pkg::FUNC_END, 8'h80);

        for (int ph = 0; ph < 4; ph++) begin
            program_nocase(!ph[0]);
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 59; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 59; end
                default: begin idle_pct = 16; stall_pct <= 16; end
            endcase
            if (ph == 2) begin
                // fill the output buffer behind a long hold-off
                hold_req <= hold_req + 1;
                repeat (12) begin
                    put_item(wgm_pkg::FUNC_NAME, random_glyph());
                    put_item(wgm_pkg::FUNC_END, 8'($urandom_range(255)));
                end
                wait_drained();
            end
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) random_burst();
        end

        wait_drained();
        stall_pct <= 0;
        repeat (TAIL) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
